// File: design/fia_pkg.sv
// ============================================================================
// fia_pkg - shared types and constants for the fractional instance allocator
// Amount format, request and result payloads, controller commands and status.
// ============================================================================
package fia_pkg;

  // Amount format: unsigned 8.16 fixed point
  localparam int AMT_W  = 24;
  localparam int FRAC_W = 16;
  localparam logic [AMT_W-1:0] UNIT_AMT = AMT_W'(1 << FRAC_W);

  // Instance storage
  localparam int MAX_INST = 8;
  localparam int IDX_W    = $clog2(MAX_INST);
  localparam int CNT_W    = 4;

  // Configuration register reset values
  localparam logic [CNT_W-1:0] INST_COUNT_RST = CNT_W'(1);
  localparam logic [AMT_W-1:0] SINGLE_CAP_RST = AMT_W'(65536);

  // Configuration register indexes
  localparam logic CFG_INSTANCE_COUNT  = 1'b0;
  localparam logic CFG_SINGLE_CAPACITY = 1'b1;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_SUB    = 2'd2,
    REQ_REFILL = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t        req_type;
    logic [2:0]       target_instance;
    logic [AMT_W-1:0] amount;
    logic             soft_request;
  } req_t;

  typedef struct packed {
    logic [2:0]       out_instance;
    logic [AMT_W-1:0] granted_amount;
    logic             ok;
    logic             last_result;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WHOLE,
    ST_FIT,
    ST_DECIDE,
    ST_ADJUST,
    ST_EMIT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_WHOLE,
    OP_FIT,
    OP_DECIDE,
    OP_ADJUST,
    OP_EMIT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
  } cmd_t;

  typedef struct packed {
    logic n_is_one;
    logic idx_last;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

// File: design/fia_ctrl.sv
// ============================================================================
// fia_ctrl - request sequencer
// Walks each request through the whole-instance, fit/drain, decide, adjust
// and result passes it needs, one datapath command per cycle unless the output stalls.
// ============================================================================
module fia_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  fia_pkg::req_type_t   in_req_type,
  output logic                 in_stall,
  input  fia_pkg::status_t     status,
  output fia_pkg::cmd_t        cmd
);

  fia_pkg::ctrl_state_t state_r;
  fia_pkg::ctrl_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fia_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd.op    = fia_pkg::OP_NONE;
    in_stall  = (state_r != fia_pkg::ST_IDLE);
    case (state_r)
      fia_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.op = fia_pkg::OP_LOAD;
          case (in_req_type)
            fia_pkg::REQ_ALLOC:
              state_nxt = status.n_is_one ? fia_pkg::ST_FIT : fia_pkg::ST_WHOLE;
            fia_pkg::REQ_REFILL:
              state_nxt = fia_pkg::ST_EMIT;
            default:
              state_nxt = fia_pkg::ST_ADJUST;
          endcase
        end
      end
      fia_pkg::ST_WHOLE: begin
        cmd.op = fia_pkg::OP_WHOLE;
        if (status.idx_last) begin
          state_nxt = fia_pkg::ST_FIT;
        end
      end
      fia_pkg::ST_FIT: begin
        cmd.op = fia_pkg::OP_FIT;
        if (status.idx_last) begin
          state_nxt = fia_pkg::ST_DECIDE;
        end
      end
      fia_pkg::ST_DECIDE: begin
        cmd.op    = fia_pkg::OP_DECIDE;
        state_nxt = fia_pkg::ST_EMIT;
      end
      fia_pkg::ST_ADJUST: begin
        cmd.op    = fia_pkg::OP_ADJUST;
        state_nxt = fia_pkg::ST_EMIT;
      end
      fia_pkg::ST_EMIT: begin
        // Hold until the output register can take a transfer
        if (status.out_free) begin
          cmd.op = fia_pkg::OP_EMIT;
          if (status.emit_last) begin
            state_nxt = fia_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = fia_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/fia_dp.sv
// ============================================================================
// fia_dp - allocator datapath
// Availability registers, working copy for rollback, per-instance grants,
// remaining demand, best-fit search and the result register.
// ============================================================================
module fia_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_index,
  input  logic [23:0]          cfg_wdata,
  input  fia_pkg::req_t        in_data,
  input  fia_pkg::cmd_t        cmd,
  output fia_pkg::status_t     status,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fia_pkg::rsp_t        out_data
);

  localparam int AW = fia_pkg::AMT_W;
  localparam int IW = fia_pkg::IDX_W;
  localparam int CW = fia_pkg::CNT_W;
  localparam int NI = fia_pkg::MAX_INST;

  // Configuration
  logic [CW-1:0]   inst_count_r;
  logic [AW-1:0]   single_cap_r;

  // Committed and working state
  logic [AW-1:0]   av_r    [NI];
  logic [AW-1:0]   av_nxt  [NI];
  logic [AW-1:0]   wav_r   [NI];
  logic [AW-1:0]   wav_nxt [NI];
  logic [AW-1:0]   alloc_r   [NI];
  logic [AW-1:0]   alloc_nxt [NI];

  // Request scratch
  fia_pkg::req_t   req_r, req_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [AW-1:0]   rem_r, rem_nxt;
  logic [AW-1:0]   slack_r, slack_nxt;
  logic [IW-1:0]   best_r, best_nxt;
  logic            found_r, found_nxt;
  logic            place_r, place_nxt;
  logic            ok_r, ok_nxt;

  // Result register
  logic            out_valid_r, out_valid_nxt;
  fia_pkg::rsp_t   out_data_r, out_data_nxt;

  // Derived values
  logic [CW-1:0]   n_used;
  logic            n_is_one;
  logic            idx_last;
  logic            tgt_bad;
  logic [IW-1:0]   idx_step;
  logic [AW-1:0]   wav_cur;
  logic [AW-1:0]   fit_slack;
  logic [AW-1:0]   place_amt;
  logic [AW:0]     free_sum;
  logic [AW-1:0]   tgt_total;
  logic [AW-1:0]   idx_total;
  logic            fit_ok;

  // Effective instance count, clamped to 1..MAX_INST
  always_comb begin
    if (inst_count_r == '0) begin
      n_used = CW'(1);
    end else if (inst_count_r > CW'(NI)) begin
      n_used = CW'(NI);
    end else begin
      n_used = inst_count_r;
    end
  end

  assign n_is_one  = (n_used == CW'(1));
  assign idx_last  = ((CW'(idx_r) + CW'(1)) == n_used);
  assign idx_step  = idx_last ? '0 : idx_r + IW'(1);
  assign tgt_bad   = (CW'(req_r.target_instance) >= n_used);
  assign wav_cur   = wav_r[idx_r];
  assign fit_slack = wav_cur - rem_r;
  assign place_amt = (place_r && (idx_r == best_r)) ? rem_r : '0;
  assign free_sum  = {1'b0, av_r[req_r.target_instance]} + {1'b0, req_r.amount};
  assign tgt_total = (n_is_one && (req_r.target_instance == '0)) ? single_cap_r
                                                                 : fia_pkg::UNIT_AMT;
  assign idx_total = (n_is_one && (idx_r == '0)) ? single_cap_r : fia_pkg::UNIT_AMT;
  assign fit_ok    = found_r && (n_is_one || (rem_r < fia_pkg::UNIT_AMT));

  // Status toward the sequencer
  always_comb begin
    status.n_is_one  = n_is_one;
    status.idx_last  = idx_last;
    status.emit_last = idx_last || (req_r.req_type == fia_pkg::REQ_FREE) ||
                       (req_r.req_type == fia_pkg::REQ_SUB);
    status.out_free  = !out_valid_r || !out_stall;
  end

  // Datapath next-state
  always_comb begin
    av_nxt        = av_r;
    wav_nxt       = wav_r;
    alloc_nxt     = alloc_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    rem_nxt       = rem_r;
    slack_nxt     = slack_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    place_nxt     = place_r;
    ok_nxt        = ok_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;

    case (cmd.op)
      // Capture the request and open a working copy
      fia_pkg::OP_LOAD: begin
        req_nxt   = in_data;
        idx_nxt   = '0;
        rem_nxt   = in_data.amount;
        slack_nxt = '0;
        best_nxt  = '0;
        found_nxt = 1'b0;
        place_nxt = 1'b0;
        ok_nxt    = 1'b0;
        wav_nxt   = av_r;
        for (int i = 0; i < NI; i++) begin
          alloc_nxt[i] = '0;
        end
      end
      // Take a whole free instance while at least 1.0 is still needed
      fia_pkg::OP_WHOLE: begin
        if ((rem_r >= fia_pkg::UNIT_AMT) && (wav_cur == fia_pkg::UNIT_AMT)) begin
          alloc_nxt[idx_r] = fia_pkg::UNIT_AMT;
          wav_nxt[idx_r]   = '0;
          rem_nxt          = rem_r - fia_pkg::UNIT_AMT;
        end
        idx_nxt = idx_step;
      end
      // Soft: drain in order. Hard: track the best fit.
      fia_pkg::OP_FIT: begin
        if (req_r.soft_request) begin
          if (!found_r) begin
            if (wav_cur >= rem_r) begin
              wav_nxt[idx_r]   = fit_slack;
              alloc_nxt[idx_r] = alloc_r[idx_r] + rem_r;
              found_nxt        = 1'b1;
            end else begin
              alloc_nxt[idx_r] = alloc_r[idx_r] + wav_cur;
              rem_nxt          = rem_r - wav_cur;
              wav_nxt[idx_r]   = '0;
            end
          end
        end else if (wav_cur >= rem_r) begin
          if (!found_r || (fit_slack < slack_r)) begin
            found_nxt = 1'b1;
            slack_nxt = fit_slack;
            best_nxt  = idx_r;
          end
        end
        idx_nxt = idx_step;
      end
      // Settle success; a hard success places the rest on the best fit
      fia_pkg::OP_DECIDE: begin
        ok_nxt    = req_r.soft_request || fit_ok;
        place_nxt = !req_r.soft_request && fit_ok;
      end
      // Free caps at the total, subtract floors at zero
      fia_pkg::OP_ADJUST: begin
        if (!tgt_bad) begin
          if (req_r.req_type == fia_pkg::REQ_FREE) begin
            av_nxt[req_r.target_instance] = (free_sum < {1'b0, tgt_total}) ?
                                            free_sum[AW-1:0] : tgt_total;
          end else if (av_r[req_r.target_instance] > req_r.amount) begin
            av_nxt[req_r.target_instance] = av_r[req_r.target_instance] - req_r.amount;
          end else begin
            av_nxt[req_r.target_instance] = '0;
          end
        end
      end
      // Load one result; a successful allocate or a refill commits this instance
      fia_pkg::OP_EMIT: begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.last_result = status.emit_last;
        case (req_r.req_type)
          fia_pkg::REQ_ALLOC: begin
            out_data_nxt.out_instance   = 3'(idx_r);
            out_data_nxt.granted_amount = ok_r ? (alloc_r[idx_r] + place_amt) : '0;
            out_data_nxt.ok             = ok_r;
            if (ok_r) begin
              av_nxt[idx_r] = wav_cur - place_amt;
            end
          end
          fia_pkg::REQ_REFILL: begin
            out_data_nxt.out_instance   = 3'(idx_r);
            out_data_nxt.granted_amount = idx_total;
            out_data_nxt.ok             = 1'b1;
            av_nxt[idx_r]               = idx_total;
          end
          default: begin
            out_data_nxt.out_instance   = req_r.target_instance;
            out_data_nxt.granted_amount = tgt_bad ? '0 : av_r[req_r.target_instance];
            out_data_nxt.ok             = !tgt_bad;
          end
        endcase
        idx_nxt = idx_step;
      end
      default: begin
      end
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inst_count_r <= fia_pkg::INST_COUNT_RST;
      single_cap_r <= fia_pkg::SINGLE_CAP_RST;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NI; i++) begin
        av_r[i] <= (i == 0) ? fia_pkg::SINGLE_CAP_RST : fia_pkg::UNIT_AMT;
      end
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          fia_pkg::CFG_INSTANCE_COUNT:  inst_count_r <= cfg_wdata[CW-1:0];
          fia_pkg::CFG_SINGLE_CAPACITY: single_cap_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      out_valid_r <= out_valid_nxt;
      av_r        <= av_nxt;
    end
  end

  // Scratch and payload registers
  always_ff @(posedge clk) begin
    wav_r      <= wav_nxt;
    alloc_r    <= alloc_nxt;
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    rem_r      <= rem_nxt;
    slack_r    <= slack_nxt;
    best_r     <= best_nxt;
    found_r    <= found_nxt;
    place_r    <= place_nxt;
    ok_r       <= ok_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/fractional_instance_allocator_core.sv
// ============================================================================
// fractional_instance_allocator_core - fractional instance allocator top level
// Tracks free 8.16 capacity of up to eight instances and serves allocate,
// free, subtract and refill requests, one result per instance reported.
// ============================================================================
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_stall    req_t (type, target, amount, soft)
//  out_     output     out_valid / out_stall  rsp_t (instance, amount, ok, last)
//  cfg_     input      cfg_wr_en              cfg_index, cfg_wdata
//
//  Every request passes through capture. Allocate with n instances in use then
//  makes a whole pass (skipped for one instance), a fit or drain pass, a decide
//  step and a result pass, each pass walking one instance per cycle over the
//  availability registers. Refill goes from capture to the result pass; free
//  and subtract take an adjust step and one result. One request is in work at a
//  time; in_stall is high from acceptance until the last result transfer is
//  loaded. Output stalls hold the result pass. Reset is synchronous, no sweep.
// ============================================================================
module fractional_instance_allocator_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  fia_pkg::req_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output fia_pkg::rsp_t    out_data,
  input  logic             cfg_wr_en,
  input  logic             cfg_index,
  input  logic [23:0]      cfg_wdata
);

  fia_pkg::cmd_t    cmd;
  fia_pkg::status_t status;

  // Sequencer
  fia_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_stall    (in_stall),
    .status      (status),
    .cmd         (cmd)
  );

  // Datapath
  fia_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
